/* rtl/gcwf_pkg.sv */
// Package with shared constants, types and the opcode length table of the command word framer.
package gcwf_pkg;

   localparam int MAX_PACKET_WORDS = 16;
   localparam int LEN_W            = $clog2(MAX_PACKET_WORDS + 1);
   localparam int QUEUE_AW         = $clog2(MAX_PACKET_WORDS) + 1;
   localparam int QUEUE_DEPTH      = 1 << QUEUE_AW;
   localparam int ENTRY_W          = 34;

   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_IMAGE  = 1'b1;

   localparam logic [7:0] OP_DRAW_MODE  = 8'hE1;
   localparam logic [7:0] OP_TEX_WINDOW = 8'hE2;
   localparam logic [7:0] OP_AREA_TL    = 8'hE3;
   localparam logic [7:0] OP_AREA_BR    = 8'hE4;
   localparam logic [7:0] OP_OFFSET     = 8'hE5;
   localparam logic [7:0] OP_MASK       = 8'hE6;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [31:0] word;
      logic        last;
      logic        commit;
   } gcwf_push_type;

   typedef struct packed {
      logic idle;
      logic full;
   } gcwf_status_type;

   typedef struct packed {
      logic [13:0] draw_mode;
      logic [19:0] texture_window;
      logic [9:0]  area_left;
      logic [9:0]  area_top;
      logic [9:0]  area_right;
      logic [9:0]  area_bottom;
      logic [10:0] offset_x;
      logic [10:0] offset_y;
      logic [1:0]  mask_setting;
   } gcwf_regs_type;

   // Packet length in words for each opcode, from the command table.
   function automatic logic [4:0] op_len(input logic [7:0] op);
      logic [4:0] len;
      len = 5'd1;
      if (op == 8'h02) len = 5'd3;
      else if (op >= 8'h20 && op <= 8'h23) len = 5'd4;
      else if (op >= 8'h24 && op <= 8'h27) len = 5'd7;
      else if (op >= 8'h28 && op <= 8'h2B) len = 5'd5;
      else if (op >= 8'h2C && op <= 8'h2F) len = 5'd9;
      else if (op >= 8'h30 && op <= 8'h33) len = 5'd6;
      else if (op >= 8'h34 && op <= 8'h37) len = 5'd9;
      else if (op >= 8'h38 && op <= 8'h3B) len = 5'd8;
      else if (op >= 8'h3C && op <= 8'h3F) len = 5'd12;
      else if (op >= 8'h40 && op <= 8'h47) len = 5'd3;
      else if (op >= 8'h48 && op <= 8'h4F) len = 5'd16;
      else if (op >= 8'h50 && op <= 8'h57) len = 5'd4;
      else if (op >= 8'h58 && op <= 8'h5F) len = 5'd16;
      else if (op >= 8'h60 && op <= 8'h62) len = 5'd3;
      else if (op >= 8'h64 && op <= 8'h67) len = 5'd4;
      else if (op == 8'h68 || op == 8'h6A) len = 5'd2;
      else if (op >= 8'h6C && op <= 8'h6F) len = 5'd3;
      else if (op == 8'h70 || op == 8'h72) len = 5'd2;
      else if (op >= 8'h74 && op <= 8'h77) len = 5'd3;
      else if (op == 8'h78 || op == 8'h7A || op == 8'h7B) len = 5'd2;
      else if (op >= 8'h7C && op <= 8'h7F) len = 5'd3;
      else if (op >= 8'h80 && op <= 8'h9F) len = 5'd4;
      else if (op >= 8'hA0 && op <= 8'hDF) len = 5'd3;
      return len;
   endfunction

   // Table length clipped to the packet buffer size.
   function automatic logic [LEN_W-1:0] sat_len(input logic [7:0] op);
      int len;
      len = int'(op_len(op));
      if (len > MAX_PACKET_WORDS) len = MAX_PACKET_WORDS;
      return LEN_W'(len);
   endfunction

endpackage

/* rtl/gcwf_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module gcwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/gcwf_front.sv */
// Front end: accepts command words, frames packets, applies environment commands.
module gcwf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,
   input  gcwf_pkg::gcwf_status_type status,
   output gcwf_pkg::gcwf_push_type   push,
   output gcwf_pkg::gcwf_regs_type   regs
);
   import gcwf_pkg::*;

   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       op_ff, op_in;
   logic             load_ff, load_in;
   logic [31:0]      remain_ff, remain_in;
   gcwf_regs_type    regs_ff, regs_in;

   logic             fire, first, done, is_env, is_img, env_first;
   logic [7:0]       cur_op;
   logic [LEN_W-1:0] cur_len;
   logic [31:0]      halves;
   logic [32:0]      words;

   function automatic logic env_op(input logic [7:0] op);
      return op == OP_DRAW_MODE || op == OP_TEX_WINDOW || op == OP_AREA_TL ||
             op == OP_AREA_BR || op == OP_OFFSET || op == OP_MASK;
   endfunction

   always_comb begin
      first     = (count_ff == '0);
      cur_op    = first ? req_tdata[31:24] : op_ff;
      cur_len   = first ? sat_len(req_tdata[31:24]) : len_ff;
      done      = (LEN_W'(count_ff + 1'b1) == cur_len);
      is_env    = env_op(cur_op);
      is_img    = (cur_op[7:5] == 3'b101);
      env_first = !load_ff && first && env_op(req_tdata[31:24]);
      // Environment updates wait for the queue to drain so in-flight results keep their values.
      req_tready = !status.full && (!env_first || status.idle);
      fire      = req_tvalid && req_tready;
      halves    = {16'd0, req_tdata[15:0]} * {16'd0, req_tdata[31:16]};
      words     = ({1'b0, halves} + 33'd1) >> 1;

      count_in  = count_ff;
      len_in    = len_ff;
      op_in     = op_ff;
      load_in   = load_ff;
      remain_in = remain_ff;
      regs_in   = regs_ff;
      push      = '0;
      push.word = req_tdata;

      if (fire) begin
         if (load_ff) begin
            push.valid  = 1'b1;
            push.kind   = KIND_IMAGE;
            push.last   = (remain_ff == 32'd1);
            push.commit = 1'b1;
            remain_in   = remain_ff - 32'd1;
            load_in     = (remain_ff != 32'd1);
         end else begin
            if (first) begin
               op_in  = cur_op;
               len_in = cur_len;
            end
            if (!is_env && !is_img) begin
               push.valid  = 1'b1;
               push.kind   = KIND_PACKET;
               push.last   = done;
               push.commit = done;
            end
            if (done) begin
               count_in = '0;
               if (is_img) begin
                  remain_in = words[31:0];
                  load_in   = (words != 33'd0);
               end
               case (cur_op)
                  OP_DRAW_MODE:  regs_in.draw_mode      = req_tdata[13:0];
                  OP_TEX_WINDOW: regs_in.texture_window = req_tdata[19:0];
                  OP_AREA_TL: begin
                     regs_in.area_left = req_tdata[9:0];
                     regs_in.area_top  = req_tdata[19:10];
                  end
                  OP_AREA_BR: begin
                     regs_in.area_right  = req_tdata[9:0];
                     regs_in.area_bottom = req_tdata[19:10];
                  end
                  OP_OFFSET: begin
                     regs_in.offset_x = req_tdata[10:0];
                     regs_in.offset_y = req_tdata[21:11];
                  end
                  OP_MASK:       regs_in.mask_setting = req_tdata[1:0];
                  default: ;
               endcase
            end else begin
               count_in = LEN_W'(count_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         load_ff   <= 1'b0;
         remain_ff <= '0;
         regs_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         load_ff   <= load_in;
         remain_ff <= remain_in;
         regs_ff   <= regs_in;
      end
      len_ff <= len_in;
      op_ff  <= op_in;
   end

   assign regs = regs_ff;
endmodule

/* rtl/gcwf_back.sv */
// Back end: word queue with commit pointer, RAM read stage and output register.
module gcwf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  gcwf_pkg::gcwf_push_type   push,
   output gcwf_pkg::gcwf_status_type status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      out_kind,
   output logic [31:0]               out_word,
   output logic                      out_last
);
   import gcwf_pkg::*;

   logic [QUEUE_AW:0]  wp_ff, wp_in, rp_ff, rp_in, cp_ff, cp_in;
   logic               pend_ff, pend_in, ov_ff, ov_in;
   logic [ENTRY_W-1:0] rd_data, out_ff, out_in;
   logic               issue, s2_free;

   gcwf_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (push.valid),
      .wr_addr (wp_ff[QUEUE_AW-1:0]),
      .wr_data ({push.kind, push.last, push.word}),
      .rd_en   (issue),
      .rd_addr (rp_ff[QUEUE_AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      s2_free = !ov_ff || rsp_tready;
      issue   = (rp_ff != cp_ff) && (!pend_ff || s2_free);
      wp_in   = push.valid ? wp_ff + 1'b1 : wp_ff;
      cp_in   = (push.valid && push.commit) ? wp_ff + 1'b1 : cp_ff;
      rp_in   = issue ? rp_ff + 1'b1 : rp_ff;
      pend_in = issue || (pend_ff && !s2_free);
      ov_in   = s2_free ? pend_ff : ov_ff;
      out_in  = (s2_free && pend_ff) ? rd_data : out_ff;
      status.full = ((wp_ff - rp_ff) == (QUEUE_AW + 1)'(QUEUE_DEPTH));
      status.idle = (wp_ff == rp_ff) && !pend_ff && !ov_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cp_ff   <= '0;
         pend_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cp_ff   <= cp_in;
         pend_ff <= pend_in;
         ov_ff   <= ov_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = ov_ff;
   assign out_kind   = out_ff[33];
   assign out_last   = out_ff[32];
   assign out_word   = out_ff[31:0];

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (cp_ff - rp_ff) <= (wp_ff - rp_ff))
      else $error("commit pointer ahead of write pointer");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !s2_free |=> pend_ff && $stable(rd_data))
      else $error("read stage lost data while stalled");
   a_nopush_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push.valid)
      else $error("push into full queue");
endmodule

/* rtl/gpu_command_word_framer_unit.sv */
// Top level of the GPU command word framer: front end, word queue and back end.
//
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  req_tdata: cmd_word
// rsp      out  rsp_tvalid/tready  rsp_tdata: data word and register values,
//                                  rsp_tlast: last_word, rsp_tuser: result_kind
//
// A command word transfer is taken every cycle while the queue has room and no environment
// command is waiting; emitted words leave at one per cycle while rsp_tready is high, from
// the queue RAM through a read stage and an output register once their packet is complete.
// Environment commands E1 to E6 hold the input until every queued result has been
// transferred, so each result carries the register values in force when it was framed.
// Reset is synchronous and clears the framer, the registers and the queue pointers.
module gpu_command_word_framer_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // cmd_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // data_word, draw_mode, texture_window, area_left, area_top, area_right,
   // area_bottom, offset_x, offset_y, mask_setting, then zero padding
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tuser    // result_kind
);
   import gcwf_pkg::*;

   gcwf_push_type   push;
   gcwf_status_type status;
   gcwf_regs_type   regs;
   logic            out_kind, out_last;
   logic [31:0]     out_word;

   // Front end frames words and applies environment commands.
   gcwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (status),
      .push       (push),
      .regs       (regs)
   );

   // Back end releases committed words in order.
   gcwf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_kind   (out_kind),
      .out_word   (out_word),
      .out_last   (out_last)
   );

   // Registers only change while the queue is empty, so the live values are correct.
   assign rsp_tdata = {6'd0, regs.mask_setting, regs.offset_y, regs.offset_x,
                       regs.area_bottom, regs.area_right, regs.area_top,
                       regs.area_left, regs.texture_window, regs.draw_mode, out_word};
   assign rsp_tlast = out_last;
   assign rsp_tuser = out_kind;
endmodule
